>>> rtl/dbba_pkg.sv
// ----------------------------------------------------------------------------
// dbba_pkg
// Shared types, constants and helpers for the data block bitmap allocator.
// ----------------------------------------------------------------------------
package dbba_pkg;

   localparam int NUM_BLOCKS    = 8192;
   localparam int MAP_WORD_BITS = 32;
   localparam int MAP_WORDS     = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

   localparam int WORD_IDX_W = $clog2(MAP_WORDS);
   localparam int BIT_IDX_W  = $clog2(MAP_WORD_BITS);
   localparam int IDX_W      = WORD_IDX_W + BIT_IDX_W;
   localparam int NWORDS_W   = WORD_IDX_W + 1;

   localparam int BASE_W  = 15;
   localparam int CNT_W   = 14;
   localparam int ADDR_W  = 16;
   localparam int CSR_W   = 15;

   localparam logic [CNT_W-1:0] NUM_BLOCKS_C = CNT_W'(NUM_BLOCKS);

   typedef logic [MAP_WORD_BITS-1:0] word_type;

   typedef enum logic [0:0] {
      CSR_DATA_BASE   = 1'b0,
      CSR_BLOCK_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_MARK  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_RANGE  = 2'd2,
      ST_DOUBLE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_MODIFY,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic decode;
      logic scan;
      logic modify;
      logic finish;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   in_range;
      logic   no_blocks;
      logic   scan_hit;
      logic   scan_last;
      logic   out_free;
   } stat_type;

   // ones in the low k bits; k of zero gives a full word
   function automatic word_type low_mask(input logic [BIT_IDX_W-1:0] k);
      word_type m;
      m = '1;
      for (int b = 0; b < MAP_WORD_BITS; b++) begin
         if (k != '0 && b >= int'(k)) begin
            m[b] = 1'b0;
         end
      end
      return m;
   endfunction

   // position of the lowest set bit
   function automatic logic [BIT_IDX_W-1:0] first_set(input word_type w);
      logic [BIT_IDX_W-1:0] p;
      p = '0;
      for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
         if (w[b]) begin
            p = BIT_IDX_W'(b);
         end
      end
      return p;
   endfunction

endpackage

>>> rtl/data_block_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// data_block_bitmap_allocator_top
// First-fit data block allocator: alloc, free, mark used and clear all over a
// used/free bitmap with a saturating free block count.
// Alloc scans up to 256 bitmap words (one bitmap RAM read per cycle) and skips
// the scan with no managed blocks; free and mark used read-modify-write one
// word, skipped when out of range; clear all needs no bitmap access.
// One request at a time; the next request is taken the cycle after the
// current one moves into the response register.
// Reset: bitmap reads as all free at once (per-word valid bits, no clearing
// pass), free count 8192, data_base 0, block_count 8192.
// ----------------------------------------------------------------------------
module data_block_bitmap_allocator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [0:0]                    csr_index,
   input  logic [dbba_pkg::CSR_W-1:0]    csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_op,
   input  logic [dbba_pkg::ADDR_W-1:0]   req_block_addr,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dbba_pkg::ADDR_W-1:0]   rsp_alloc_addr,
   output logic [1:0]                    rsp_status,
   output logic [dbba_pkg::CNT_W-1:0]    rsp_free_left
);

   logic [dbba_pkg::BASE_W-1:0] data_base_ff;
   logic [dbba_pkg::CNT_W-1:0]  block_count_ff;
   dbba_pkg::cmd_type           cmd;
   dbba_pkg::stat_type          stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_base_ff   <= '0;
         block_count_ff <= dbba_pkg::NUM_BLOCKS_C;
      end else if (csr_we) begin
         case (dbba_pkg::csr_index_type'(csr_index))
            dbba_pkg::CSR_DATA_BASE: begin
               data_base_ff <= csr_wdata[dbba_pkg::BASE_W-1:0];
            end
            dbba_pkg::CSR_BLOCK_COUNT: begin
               block_count_ff <= csr_wdata[dbba_pkg::CNT_W-1:0];
            end
            default: begin
               data_base_ff <= data_base_ff;
            end
         endcase
      end
   end

   dbba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   dbba_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .data_base      (data_base_ff),
      .block_count    (block_count_ff),
      .req_op         (req_op),
      .req_block_addr (req_block_addr),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_alloc_addr (rsp_alloc_addr),
      .rsp_status     (rsp_status),
      .rsp_free_left  (rsp_free_left)
   );

endmodule

>>> rtl/dbba_ram.sv
// ----------------------------------------------------------------------------
// dbba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dbba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/dbba_ctrl.sv
// ----------------------------------------------------------------------------
// dbba_ctrl
// Sequencer for one request at a time: decode, word scan or read-modify-write,
// then hand-off to the response register.
// ----------------------------------------------------------------------------
module dbba_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  dbba_pkg::stat_type stat,
   output dbba_pkg::cmd_type  cmd
);

   dbba_pkg::state_type state_ff;
   dbba_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dbba_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         dbba_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = dbba_pkg::S_DECODE;
            end
         end
         dbba_pkg::S_DECODE: begin
            cmd.decode = 1'b1;
            case (stat.op)
               dbba_pkg::OP_ALLOC: begin
                  state_in = stat.no_blocks ? dbba_pkg::S_FINISH : dbba_pkg::S_SCAN;
               end
               dbba_pkg::OP_FREE, dbba_pkg::OP_MARK: begin
                  state_in = stat.in_range ? dbba_pkg::S_MODIFY : dbba_pkg::S_FINISH;
               end
               default: begin
                  state_in = dbba_pkg::S_FINISH;
               end
            endcase
         end
         dbba_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_hit || stat.scan_last) begin
               state_in = dbba_pkg::S_FINISH;
            end
         end
         dbba_pkg::S_MODIFY: begin
            cmd.modify = 1'b1;
            state_in   = dbba_pkg::S_FINISH;
         end
         dbba_pkg::S_FINISH: begin
            cmd.finish = 1'b1;
            if (stat.out_free) begin
               state_in = dbba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dbba_pkg::S_IDLE;
         end
      endcase
   end

   a_finish_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dbba_pkg::S_FINISH && stat.out_free) |=> state_ff == dbba_pkg::S_IDLE)
      else $error("finish did not return to idle");

   a_scan_stops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dbba_pkg::S_SCAN && (stat.scan_hit || stat.scan_last))
      |=> state_ff == dbba_pkg::S_FINISH)
      else $error("scan ran past its end");

   a_decode_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == dbba_pkg::S_DECODE)
      else $error("accepted request not decoded");

endmodule

>>> rtl/dbba_dpath.sv
// ----------------------------------------------------------------------------
// dbba_dpath
// Bitmap store with per-word valid bits, free counter, range check, lowest
// free bit search and response register.
// ----------------------------------------------------------------------------
module dbba_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  dbba_pkg::cmd_type                   cmd,
   output dbba_pkg::stat_type                  stat,
   input  logic [dbba_pkg::BASE_W-1:0]         data_base,
   input  logic [dbba_pkg::CNT_W-1:0]          block_count,
   input  logic [1:0]                          req_op,
   input  logic [dbba_pkg::ADDR_W-1:0]         req_block_addr,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dbba_pkg::ADDR_W-1:0]         rsp_alloc_addr,
   output logic [1:0]                          rsp_status,
   output logic [dbba_pkg::CNT_W-1:0]          rsp_free_left
);

   dbba_pkg::op_type                   op_ff;
   logic [dbba_pkg::ADDR_W-1:0]        addr_ff;
   logic [dbba_pkg::WORD_IDX_W-1:0]    scan_word_ff;
   logic [dbba_pkg::MAP_WORDS-1:0]     vld_ff;
   logic                               vld_q_ff;
   logic [dbba_pkg::CNT_W-1:0]         cnt_ff;
   logic [dbba_pkg::ADDR_W-1:0]        res_addr_ff;
   dbba_pkg::status_type               res_status_ff;
   logic                               rsp_valid_ff;
   logic [dbba_pkg::ADDR_W-1:0]        rsp_alloc_addr_ff;
   dbba_pkg::status_type               rsp_status_ff;
   logic [dbba_pkg::CNT_W-1:0]         rsp_free_left_ff;

   logic [dbba_pkg::CNT_W-1:0]         n_eff;
   logic [dbba_pkg::CNT_W:0]           n_round;
   logic [dbba_pkg::NWORDS_W-1:0]      nwords;
   logic [dbba_pkg::ADDR_W:0]          diff;
   logic                               in_range;
   logic [dbba_pkg::IDX_W-1:0]         idx;
   logic [dbba_pkg::WORD_IDX_W-1:0]    idx_word;
   logic [dbba_pkg::BIT_IDX_W-1:0]     idx_bit;
   dbba_pkg::word_type                 word_q;
   dbba_pkg::word_type                 scan_mask;
   dbba_pkg::word_type                 free_vec;
   logic [dbba_pkg::BIT_IDX_W-1:0]     hit_bit;
   logic                               scan_hit;
   logic                               scan_last;
   logic                               bit_used;
   logic                               out_free;
   logic [dbba_pkg::ADDR_W-1:0]        hit_addr;

   logic                               ram_we;
   logic [dbba_pkg::WORD_IDX_W-1:0]    ram_waddr;
   dbba_pkg::word_type                 ram_wdata;
   logic [dbba_pkg::WORD_IDX_W-1:0]    ram_raddr;
   dbba_pkg::word_type                 ram_rdata;

   assign n_eff    = (block_count > dbba_pkg::NUM_BLOCKS_C) ? dbba_pkg::NUM_BLOCKS_C
                                                            : block_count;
   assign n_round  = {1'b0, n_eff} + (dbba_pkg::CNT_W + 1)'(dbba_pkg::MAP_WORD_BITS - 1);
   assign nwords   = dbba_pkg::NWORDS_W'(n_round >> dbba_pkg::BIT_IDX_W);

   assign diff     = {1'b0, addr_ff}
                   - (dbba_pkg::ADDR_W + 1)'(data_base);
   assign in_range = !diff[dbba_pkg::ADDR_W]
                     && (diff[dbba_pkg::ADDR_W-1:0] < dbba_pkg::ADDR_W'(n_eff));
   assign idx      = diff[dbba_pkg::IDX_W-1:0];
   assign idx_word = idx[dbba_pkg::IDX_W-1:dbba_pkg::BIT_IDX_W];
   assign idx_bit  = idx[dbba_pkg::BIT_IDX_W-1:0];

   assign word_q    = vld_q_ff ? ram_rdata : '0;
   assign scan_last = ({1'b0, scan_word_ff} == (nwords - dbba_pkg::NWORDS_W'(1)));
   assign scan_mask = scan_last ? dbba_pkg::low_mask(n_eff[dbba_pkg::BIT_IDX_W-1:0]) : '1;
   assign free_vec  = ~word_q & scan_mask;
   assign scan_hit  = |free_vec;
   assign hit_bit   = dbba_pkg::first_set(free_vec);
   assign hit_addr  = dbba_pkg::ADDR_W'(data_base)
                    + dbba_pkg::ADDR_W'({scan_word_ff, hit_bit});
   assign bit_used  = word_q[idx_bit];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign stat.op        = op_ff;
   assign stat.in_range  = in_range;
   assign stat.no_blocks = (n_eff == '0);
   assign stat.scan_hit  = scan_hit;
   assign stat.scan_last = scan_last;
   assign stat.out_free  = out_free;

   always_comb begin
      ram_raddr = scan_word_ff + dbba_pkg::WORD_IDX_W'(1);
      if (cmd.decode) begin
         ram_raddr = (op_ff == dbba_pkg::OP_ALLOC) ? '0 : idx_word;
      end
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = idx_word;
      ram_wdata = word_q | (dbba_pkg::word_type'(1) << idx_bit);
      if (cmd.scan) begin
         ram_we    = scan_hit;
         ram_waddr = scan_word_ff;
         ram_wdata = word_q | (dbba_pkg::word_type'(1) << hit_bit);
      end else if (cmd.modify) begin
         if (op_ff == dbba_pkg::OP_FREE) begin
            ram_we    = bit_used;
            ram_wdata = word_q & ~(dbba_pkg::word_type'(1) << idx_bit);
         end else begin
            ram_we    = 1'b1;
         end
      end
   end

   dbba_ram #(
      .WIDTH (dbba_pkg::MAP_WORD_BITS),
      .DEPTH (dbba_pkg::MAP_WORDS)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      vld_q_ff <= vld_ff[ram_raddr];
      if (cmd.load) begin
         op_ff   <= dbba_pkg::op_type'(req_op);
         addr_ff <= req_block_addr;
      end
      if (cmd.decode) begin
         scan_word_ff  <= '0;
         res_addr_ff   <= '0;
         if (op_ff == dbba_pkg::OP_ALLOC && n_eff == '0) begin
            res_status_ff <= dbba_pkg::ST_FULL;
         end else if ((op_ff == dbba_pkg::OP_FREE || op_ff == dbba_pkg::OP_MARK)
                      && !in_range) begin
            res_status_ff <= dbba_pkg::ST_RANGE;
         end else begin
            res_status_ff <= dbba_pkg::ST_OK;
         end
      end
      if (cmd.scan) begin
         scan_word_ff <= scan_word_ff + dbba_pkg::WORD_IDX_W'(1);
         if (scan_hit) begin
            res_addr_ff <= hit_addr;
         end else if (scan_last) begin
            res_status_ff <= dbba_pkg::ST_FULL;
         end
      end
      if (cmd.modify && op_ff == dbba_pkg::OP_FREE && !bit_used) begin
         res_status_ff <= dbba_pkg::ST_DOUBLE;
      end
      if (cmd.finish && out_free) begin
         rsp_alloc_addr_ff <= res_addr_ff;
         rsp_status_ff     <= res_status_ff;
         rsp_free_left_ff  <= cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         cnt_ff       <= dbba_pkg::NUM_BLOCKS_C;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ram_we) begin
            vld_ff[ram_waddr] <= 1'b1;
         end
         if (cmd.decode && op_ff == dbba_pkg::OP_CLEAR) begin
            vld_ff <= '0;
            cnt_ff <= n_eff;
         end
         if (cmd.scan && scan_hit && cnt_ff != '0) begin
            cnt_ff <= cnt_ff - dbba_pkg::CNT_W'(1);
         end
         if (cmd.modify && op_ff == dbba_pkg::OP_FREE && bit_used && cnt_ff < n_eff) begin
            cnt_ff <= cnt_ff + dbba_pkg::CNT_W'(1);
         end
         if (cmd.finish && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alloc_addr = rsp_alloc_addr_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_free_left  = rsp_free_left_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= dbba_pkg::NUM_BLOCKS_C)
      else $error("free counter above block total");

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (cmd.scan || cmd.modify))
      else $error("map written outside scan or modify");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish))
      else $error("response raised without finish");

endmodule
